### design/crb_pkg.sv
`default_nettype none

package crb_pkg;

  localparam int CRB_PORTS = 16;
  localparam int CRB_TARGETS = 4;

  localparam int ADDR_BITS = 8;
  localparam int DATA_BITS = 16;
  localparam logic [7:0] ADDR_MASK = 8'hFF >> (8 - ADDR_BITS);
  localparam logic [15:0] DATA_MASK = 16'hFFFF >> (16 - DATA_BITS);

  localparam logic [7:0] TIMEOUT_RESET = 8'd100;

  localparam logic [1:0] MODE_RR = 2'd0;

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_IDLE_TIMEOUT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  port;
    logic        is_write;
    logic [1:0]  target;
    logic [7:0]  addr;
    logic [15:0] wdata;
    logic [15:0] tag;
    logic [1:0]  prio;
    logic [31:0] issue_time;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        granted;
    logic [3:0]  grant_port;
    logic [1:0]  grant_target;
    logic        grant_is_write;
    logic [7:0]  grant_addr;
    logic [15:0] grant_data;
    logic [15:0] grant_tag;
    logic [1:0]  grant_prio;
    logic        stopped;
  } rsp_t;

  typedef struct packed {
    logic        is_write;
    logic [1:0]  target;
    logic [7:0]  addr;
    logic [15:0] wdata;
    logic [15:0] tag;
    logic [1:0]  prio;
    logic [31:0] issue_time;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

endpackage

`default_nettype wire

### design/crb_ram.sv
`default_nettype none

module crb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/crossbar_request_arbiter.sv
// Request arbiter of a many-to-few crossbar.
// Channels: req (valid/stall) carries one item, either an arrive that offers a
// request for a port's holding slot, or a tick that grants at most one held
// request. rsp (valid/stall) returns exactly one item per req item, in order.
// cfg_we/cfg_index/cfg_data write mode (index 0) and idle_timeout (index 1);
// write only while the block is idle.
// Flow: an arrive, or a tick after stop, gives its result at the accepting
// edge. A live tick scans every slot through the single read port of the
// slot RAM, one slot a cycle, in state SCAN, then loads its result in state
// COMMIT; no new item is taken until the block is back in idle.
// Reset (rst, synchronous): all slots empty, mode round robin, timeout 100,
// pointer zero, not stopped. The slot RAM needs no clearing pass.
// A stalled result holds in the output register; req_stall stays high while
// a tick is in progress or while a held result cannot be drained.
`default_nettype none

module crossbar_request_arbiter import crb_pkg::*; #(
  parameter int PORTS   = CRB_PORTS,
  parameter int TARGETS = CRB_TARGETS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire req_t       req,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output rsp_t            rsp,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int IDXW = $clog2(PORTS);
  localparam int CNTW = $clog2(PORTS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(PORTS - 1);
  localparam logic [CNTW-1:0] SCAN_LEN = CNTW'(PORTS);

  state_t           state;
  logic [PORTS-1:0] slot_valid;
  logic [1:0]       mode;
  logic [7:0]       idle_timeout;
  logic [7:0]       idle_count;
  logic             halted;
  logic [IDXW-1:0]  rr_pointer;
  logic [IDXW-1:0]  rd_port;
  logic [CNTW-1:0]  scan_cnt;
  logic             best_found;
  logic [IDXW-1:0]  best_port;
  slot_t            best;

  logic            out_free;
  logic            req_take;
  logic            is_rr;
  logic [IDXW-1:0] scan_start;
  logic [IDXW-1:0] arr_idx;
  logic            arr_ok;
  logic [IDXW-1:0] rd_next_port;
  logic [IDXW-1:0] ram_raddr;
  slot_t           ram_rdata;
  slot_t           ram_wdata;
  logic            ram_we;
  logic            cand_better;
  logic            rsp_load;
  rsp_t            rsp_next;

  assign out_free   = !rsp_valid || !rsp_stall;
  assign req_stall  = (state != ST_IDLE) || !out_free;
  assign req_take   = req_valid && !req_stall;
  assign is_rr      = (mode == MODE_RR);
  assign scan_start = is_rr ? rr_pointer : '0;
  assign arr_idx    = IDXW'(req.port);
  assign arr_ok     = (int'(req.port) < PORTS) && (int'(req.target) < TARGETS) &&
                      !slot_valid[arr_idx];

  assign ram_we = (state == ST_IDLE) && req_take && (req.req_type == REQ_ARRIVE) && arr_ok;
  assign ram_wdata = '{
    is_write:   req.is_write,
    target:     req.target,
    addr:       req.addr & ADDR_MASK,
    wdata:      req.wdata & DATA_MASK,
    tag:        req.tag,
    prio:       req.prio,
    issue_time: req.issue_time
  };

  assign rd_next_port = (rd_port == LAST_IDX) ? '0 : rd_port + 1'b1;
  assign ram_raddr    = (state == ST_IDLE) ? scan_start : rd_next_port;

  crb_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(PORTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(arr_idx),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cand_better = slot_valid[rd_port] &&
                       (!best_found ||
                        (!is_rr && ((ram_rdata.prio > best.prio) ||
                                    ((ram_rdata.prio == best.prio) &&
                                     (ram_rdata.issue_time < best.issue_time)))));

  always_comb begin
    rsp_next = '0;
    rsp_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          if (req.req_type == REQ_ARRIVE) begin
            rsp_load          = 1'b1;
            rsp_next.accepted = arr_ok;
            rsp_next.stopped  = halted;
          end else if (halted) begin
            rsp_load         = 1'b1;
            rsp_next.stopped = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        rsp_load = 1'b0;
      end
      ST_COMMIT: begin
        rsp_load = 1'b1;
        if (best_found) begin
          rsp_next.granted        = 1'b1;
          rsp_next.grant_port     = 4'(best_port);
          rsp_next.grant_target   = best.target;
          rsp_next.grant_is_write = best.is_write;
          rsp_next.grant_addr     = best.addr;
          rsp_next.grant_data     = best.wdata;
          rsp_next.grant_tag      = best.tag;
          rsp_next.grant_prio     = best.prio;
          rsp_next.stopped        = halted;
        end else begin
          rsp_next.stopped = (idle_count <= 8'd1);
        end
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_valid   <= '0;
      mode         <= MODE_RR;
      idle_timeout <= TIMEOUT_RESET;
      idle_count   <= TIMEOUT_RESET;
      halted       <= 1'b0;
      rr_pointer   <= '0;
      rd_port      <= '0;
      scan_cnt     <= '0;
      best_found   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:         mode <= cfg_data[1:0];
          CFG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
          default:          mode <= mode;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (req_take) begin
            if (req.req_type == REQ_ARRIVE) begin
              if (arr_ok) begin
                slot_valid[arr_idx] <= 1'b1;
              end
            end else if (!halted) begin
              state      <= ST_SCAN;
              rd_port    <= scan_start;
              scan_cnt   <= CNTW'(1);
              best_found <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (cand_better) begin
            best_found <= 1'b1;
            best_port  <= rd_port;
          end
          if (scan_cnt == SCAN_LEN) begin
            state <= ST_COMMIT;
          end else begin
            rd_port  <= rd_next_port;
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        ST_COMMIT: begin
          state <= ST_IDLE;
          if (best_found) begin
            slot_valid[best_port] <= 1'b0;
            idle_count            <= idle_timeout;
            if (is_rr) begin
              rr_pointer <= (best_port == LAST_IDX) ? '0 : best_port + 1'b1;
            end
          end else if (idle_count <= 8'd1) begin
            idle_count <= '0;
            halted     <= 1'b1;
          end else begin
            idle_count <= idle_count - 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && cand_better) begin
      best <= ram_rdata;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

### design/crb_checker.sv
`default_nettype none

module crb_checker import crb_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  logic seen_stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_stop <= 1'b0;
    end else if (rsp_valid && !rsp_stall && rsp.stopped) begin
      seen_stop <= 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled item changed");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.granted |-> rsp.grant_port == '0 && rsp.grant_target == '0 &&
      !rsp.grant_is_write && rsp.grant_addr == '0 && rsp.grant_data == '0 &&
      rsp.grant_tag == '0 && rsp.grant_prio == '0)
    else $error("grant fields set without grant");

  a_accept_xor_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.accepted && rsp.granted))
    else $error("item both accepted and granted");

  a_grant_not_stopped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.granted |-> !rsp.stopped)
    else $error("grant after stop");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && seen_stop |-> rsp.stopped)
    else $error("stop flag cleared");

endmodule

bind crossbar_request_arbiter crb_checker u_crb_checker (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

`default_nettype wire

### dv/crossbar_request_arbiter_test.sv
module crossbar_request_arbiter_test;
  import crb_pkg::*;

  localparam logic [1:0] MODE_PRIO = 2'd1;
  localparam logic [1:0] MODE_PRIO_ALT = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 265;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NO_PRESSURE = 0;
  localparam int HOLD_LONG = 1;
  localparam int PAUSE_MID = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_MODE;
  logic [7:0] cfg_data = '0;

  crossbar_request_arbiter uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  req_t queued_requests[$];
  rsp_t awaited_responses[$];
  rsp_t want;
  int failures = 0;
  int cycle_count = 0;

  bit sender_gaps = 1'b0;
  int recv_style = 1;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_phase = 0;
  int burst_left = 0;
  int gap_left = 0;

  bit slot_full [CRB_PORTS];
  slot_t slot_held [CRB_PORTS];
  int next_rr;
  logic [7:0] idle_left;
  bit stop_flag;
  logic [1:0] cur_mode;
  logic [7:0] cur_timeout;

  function automatic rsp_t arbitrate(input req_t r);
    rsp_t o;
    int win;
    int k;
    int p;
    o = '0;
    if (r.req_type == REQ_ARRIVE) begin
      if (int'(r.port) < CRB_PORTS && int'(r.target) < CRB_TARGETS && !slot_full[r.port]) begin
        slot_held[r.port] = slot_t'{r.is_write, r.target, r.addr & ADDR_MASK,
                                    r.wdata & DATA_MASK, r.tag, r.prio, r.issue_time};
        slot_full[r.port] = 1'b1;
        o.accepted = 1'b1;
      end
    end else if (!stop_flag) begin
      win = -1;
      if (cur_mode == MODE_RR) begin
        for (k = 0; k < CRB_PORTS && win < 0; k++) begin
          p = (next_rr + k) % CRB_PORTS;
          if (slot_full[p]) win = p;
        end
      end else begin
        for (p = 0; p < CRB_PORTS; p++) begin
          if (slot_full[p] && (win < 0 || slot_held[p].prio > slot_held[win].prio ||
              (slot_held[p].prio == slot_held[win].prio &&
               slot_held[p].issue_time < slot_held[win].issue_time)))
            win = p;
        end
      end
      if (win >= 0) begin
        o.granted = 1'b1;
        o.grant_port = win[3:0];
        o.grant_target = slot_held[win].target;
        o.grant_is_write = slot_held[win].is_write;
        o.grant_addr = slot_held[win].addr;
        o.grant_data = slot_held[win].wdata;
        o.grant_tag = slot_held[win].tag;
        o.grant_prio = slot_held[win].prio;
        slot_full[win] = 1'b0;
        if (cur_mode == MODE_RR) next_rr = (win + 1) % CRB_PORTS;
        idle_left = cur_timeout;
      end else if (idle_left <= 8'd1) begin
        idle_left = 8'd0;
        stop_flag = 1'b1;
      end else begin
        idle_left = idle_left - 8'd1;
      end
    end
    o.stopped = stop_flag;
    return o;
  endfunction

  function automatic req_t any_arrive(input logic [3:0] p);
    req_t r;
    r = '0;
    r.req_type = REQ_ARRIVE;
    r.port = p;
    r.is_write = 1'($urandom_range(0, 1));
    r.target = 2'($urandom_range(0, 3));
    r.addr = 8'($urandom);
    r.wdata = 16'($urandom);
    r.tag = 16'($urandom);
    r.prio = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0, 1: r.issue_time = $urandom_range(0, 3);
      2: r.issue_time = '1;
      default: r.issue_time = $urandom;
    endcase
    return r;
  endfunction

  function automatic req_t arrive_at(input logic [3:0] p, input logic [1:0] pr,
                                     input logic [31:0] t);
    req_t r;
    r = any_arrive(p);
    r.prio = pr;
    r.issue_time = t;
    return r;
  endfunction

  function automatic req_t tick_item();
    req_t r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.req_type = REQ_TICK;
    return r;
  endfunction

  task automatic queue_item(input req_t r);
    queued_requests.insert(queued_requests.size(), r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (queued_requests.size() != 0 || req_valid || awaited_responses.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) cur_mode = val[1:0];
    else cur_timeout = val;
  endtask

  task automatic fill_traffic(input int n);
    int made;
    int k;
    int i;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 6) begin
        k = $urandom_range(1, CRB_PORTS);
        for (i = 0; i < k; i++) queue_item(any_arrive(4'($urandom_range(0, 15))));
        for (i = 0; i < k; i++) queue_item(tick_item());
        made += 2 * k;
      end else begin
        k = $urandom_range(1, 8);
        for (i = 0; i < k; i++)
          queue_item($urandom_range(0, 1) ? tick_item()
                                          : any_arrive(4'($urandom_range(0, 15))));
        made += k;
      end
    end
  endtask

  task automatic run_phase(input logic [1:0] m, input logic [7:0] t, input bit gaps,
                           input int style, input int pressure);
    drain();
    write_reg(CFG_MODE, {6'd0, m});
    write_reg(CFG_IDLE_TIMEOUT, t);
    @(negedge clk);
    sender_gaps = gaps;
    recv_style = style;
    if (pressure == PAUSE_MID) begin
      fill_traffic(PHASE_ITEMS / 2);
      drain();
      fill_traffic(PHASE_ITEMS / 2);
    end else begin
      fill_traffic(PHASE_ITEMS);
      if (pressure == HOLD_LONG) hold_req++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[crossbar_request_arbiter] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (req_valid && !req_stall)
        awaited_responses.insert(awaited_responses.size(), arbitrate(req));
      if (!req_valid || !req_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          req <= queued_requests.pop_front();
          req_valid <= 1'b1;
          if (sender_gaps) begin
            if (burst_left <= 1) begin
              burst_left <= $urandom_range(1, 10);
              gap_left <= $urandom_range(1, 8);
            end else begin
              burst_left <= burst_left - 1;
            end
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 7;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      case (recv_style)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 2) == 0);
        default: rsp_stall <= (stall_phase < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_responses.size() == 0) begin
        $error("result with nothing outstanding");
        failures++;
      end else begin
        want = awaited_responses.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
        check_field("granted", 32'(want.granted), 32'(rsp.granted));
        check_field("grant_port", 32'(want.grant_port), 32'(rsp.grant_port));
        check_field("grant_target", 32'(want.grant_target), 32'(rsp.grant_target));
        check_field("grant_is_write", 32'(want.grant_is_write), 32'(rsp.grant_is_write));
        check_field("grant_addr", 32'(want.grant_addr), 32'(rsp.grant_addr));
        check_field("grant_data", 32'(want.grant_data), 32'(rsp.grant_data));
        check_field("grant_tag", 32'(want.grant_tag), 32'(rsp.grant_tag));
        check_field("grant_prio", 32'(want.grant_prio), 32'(rsp.grant_prio));
        check_field("stopped", 32'(want.stopped), 32'(rsp.stopped));
      end
    end
  end

  initial begin
    foreach (slot_full[i]) slot_full[i] = 1'b0;
    next_rr = 0;
    cur_mode = MODE_RR;
    cur_timeout = TIMEOUT_RESET;
    idle_left = TIMEOUT_RESET;
    stop_flag = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    queue_item(req_t'{REQ_ARRIVE, 4'd0, 1'b1, 2'd3, 8'hFF, 16'hFFFF, 16'hFFFF,
                      2'd3, 32'hFFFF_FFFF});
    queue_item(any_arrive(4'd0));
    queue_item(req_t'{REQ_ARRIVE, 4'd15, 1'b0, 2'd0, 8'h00, 16'h0000,
                      16'h0000, 2'd0, 32'h0});
    repeat (3) queue_item(tick_item());
    queue_item(any_arrive(4'd3));
    queue_item(any_arrive(4'd9));
    queue_item(any_arrive(4'd12));
    queue_item(tick_item());
    queue_item(any_arrive(4'd1));
    repeat (3) queue_item(tick_item());
    drain();
    write_reg(CFG_MODE, {6'd0, MODE_PRIO});
    @(negedge clk);
    queue_item(arrive_at(4'd2, 2'd1, 32'd5));
    queue_item(arrive_at(4'd5, 2'd3, 32'd100));
    queue_item(arrive_at(4'd7, 2'd3, 32'd50));
    queue_item(arrive_at(4'd1, 2'd3, 32'd50));
    queue_item(arrive_at(4'd0, 2'd0, 32'd0));
    repeat (5) queue_item(tick_item());

    run_phase(MODE_RR, 8'd255, 1'b0, 0, NO_PRESSURE);
    run_phase(MODE_PRIO, 8'd32, 1'b1, 1, NO_PRESSURE);
    run_phase(MODE_PRIO_ALT, 8'd200, 1'b0, 2, HOLD_LONG);
    run_phase(MODE_UNUSED, 8'd64, 1'b1, 0, NO_PRESSURE);
    run_phase(MODE_RR, 8'd100, 1'b1, 2, PAUSE_MID);
    run_phase(MODE_PRIO, 8'd255, 1'b0, 1, NO_PRESSURE);
    run_phase(MODE_RR, 8'd40, 1'b1, 1, NO_PRESSURE);

    // drive the idle counter to zero and check that the stop sticks
    drain();
    write_reg(CFG_IDLE_TIMEOUT, 8'd1);
    @(negedge clk);
    queue_item(any_arrive(4'd4));
    queue_item(tick_item());
    drain();
    write_reg(CFG_IDLE_TIMEOUT, 8'd0);
    @(negedge clk);
    queue_item(any_arrive(4'd6));
    queue_item(tick_item());
    queue_item(tick_item());
    queue_item(any_arrive(4'd6));
    queue_item(tick_item());
    queue_item(any_arrive(4'd6));
    queue_item(tick_item());
    drain();
    repeat (30) @(posedge clk);

    if (failures == 0 && awaited_responses.size() == 0)
      $display("[crossbar_request_arbiter] OK");
    else
      $display("[crossbar_request_arbiter] ERROR");
    $finish;
  end

endmodule
